// ===== rtl/sbr_pkg.sv =====
package sbr_pkg;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned FieldWidth = 32;
    localparam int unsigned FracShift = 30;
    localparam int unsigned ProdWidth = 2 * FieldWidth;
    localparam int unsigned SumWidth = ProdWidth + 2;
    localparam logic [1:0] OP_TRANSFORM = 2'd0;
    localparam logic [1:0] OP_LOAD_TRANS = 2'd1;
    localparam logic [1:0] OP_LOAD_ROT = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [FieldWidth-1:0] QOne = 32'sh4000_0000;

    typedef logic signed [FieldWidth-1:0] t_word;
    typedef t_word t_mat [9];
    typedef logic signed [ProdWidth-1:0] t_prod;
endpackage

// ===== rtl/sbr_dot_stage.sv =====
module sbr_dot_stage #(
    parameter int unsigned DATA_WIDTH = sbr_pkg::DataWidth
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  sbr_pkg::t_mat  i_a,
    input  sbr_pkg::t_mat  i_b,
    input  logic           i_a_transposed,
    output sbr_pkg::t_mat  o_res
);
    import sbr_pkg::*;

    localparam int unsigned EffWidth = (DATA_WIDTH > FieldWidth) ? FieldWidth : DATA_WIDTH;
    localparam logic signed [SumWidth-1:0] SatHi = (SumWidth'(1) <<< (EffWidth - 1)) - 1;
    localparam logic signed [SumWidth-1:0] SatLo = -SatHi - 1;
    localparam logic signed [SumWidth-1:0] Half = SumWidth'(1) <<< (FracShift - 1);

    t_prod r_prod [9][3];
    t_mat  n_res;

    // products registered, then sum, round, saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    for (int m = 0; m < 3; m++) begin
                        r_prod[r*3+c][m] <= (i_a_transposed ? ProdWidth'(i_a[m*3+r])
                                                           : ProdWidth'(i_a[r*3+m]))
                                            * ProdWidth'(i_b[m*3+c]);
                    end
                end
            end
        end
    end

    always_comb begin
        logic signed [SumWidth-1:0] s;
        logic signed [SumWidth-1:0] q;
        for (int e = 0; e < 9; e++) begin
            s = SumWidth'(r_prod[e][0]) + SumWidth'(r_prod[e][1]) + SumWidth'(r_prod[e][2])
                + Half;
            q = s >>> FracShift;
            if (q > SatHi) n_res[e] = t_word'(SatHi);
            else if (q < SatLo) n_res[e] = t_word'(SatLo);
            else n_res[e] = t_word'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_res <= n_res;
    end
endmodule

// ===== rtl/stiffness_block_rotation.sv =====
// stiffness_block_rotation
// rotates one 3x3 stiffness block to global axes: G = Brow^T * K * Bcol
// input channel i_valid/o_ready carries operation, flags and k_00..k_22
// operation 1 or 2 loads the translational or rotational matrix (Q1.30),
// taking effect for the very next transferred item; no result is produced
// operation 0 returns one result on o_valid/i_ready as g_00..g_22 (Q16.16)
// operation 3 is dropped
// the path from input transfer to result valid is two multiply
// stages, each a product register then a sum/round/saturate register
// throughput is one item per cycle; the whole pipeline advances together
// and holds when the output register is full and the receiver stalls, so
// o_ready is high whenever the output stage is empty or being taken
// reset makes both matrices identity and clears all valid bits
module stiffness_block_rotation #(
    parameter int unsigned DATA_WIDTH = sbr_pkg::DataWidth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_operation,
    input  logic                 i_row_rotational,
    input  logic                 i_col_rotational,
    input  logic signed [31:0]   i_k_00, i_k_01, i_k_02,
    input  logic signed [31:0]   i_k_10, i_k_11, i_k_12,
    input  logic signed [31:0]   i_k_20, i_k_21, i_k_22,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_g_00, o_g_01, o_g_02,
    output logic signed [31:0]   o_g_10, o_g_11, o_g_12,
    output logic signed [31:0]   o_g_20, o_g_21, o_g_22
);
    import sbr_pkg::*;

    t_mat r_trans, r_rot, r_brow1, r_brow2, w_k, w_bcol, w_t, w_g;
    logic [3:0] r_vld;
    logic w_adv, w_xfer;

    assign w_k = '{i_k_00, i_k_01, i_k_02, i_k_10, i_k_11, i_k_12, i_k_20, i_k_21, i_k_22};
    assign w_adv = !r_vld[3] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[3];
    assign w_xfer = i_valid && o_ready;
    assign w_bcol = i_col_rotational ? r_rot : r_trans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int e = 0; e < 9; e++) begin
                r_trans[e] <= (e % 4 == 0) ? QOne : '0;
                r_rot[e]   <= (e % 4 == 0) ? QOne : '0;
            end
        end else begin
            if (w_adv) r_vld <= {r_vld[2:0], w_xfer && (i_operation == OP_TRANSFORM)};
            if (w_xfer && i_operation == OP_LOAD_TRANS) r_trans <= w_k;
            if (w_xfer && i_operation == OP_LOAD_ROT) r_rot <= w_k;
        end
    end

    // brow travels alongside the first stage
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_brow1 <= i_row_rotational ? r_rot : r_trans;
            r_brow2 <= r_brow1;
        end
    end

    sbr_dot_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage1 (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_k), .i_b(w_bcol),
        .i_a_transposed(1'b0), .o_res(w_t)
    );

    sbr_dot_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage2 (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r_brow2), .i_b(w_t),
        .i_a_transposed(1'b1), .o_res(w_g)
    );

    assign {o_g_00, o_g_01, o_g_02} = {w_g[0], w_g[1], w_g[2]};
    assign {o_g_10, o_g_11, o_g_12} = {w_g[3], w_g[4], w_g[5]};
    assign {o_g_20, o_g_21, o_g_22} = {w_g[6], w_g[7], w_g[8]};

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_g_00))
        else $error("result lost under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("ready low with empty output");
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !r_vld[2] |=> !o_valid)
        else $error("result invented");
`endif
endmodule
